// File: src/csv_field_tokenizer_core_defines.svh
// Assertion macros used by the tokenizer parser RTL.
`ifndef CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps

package cft_pkg;

    // Default counter limits.
    localparam int COLUMN_LIMIT_DEF = 255;
    localparam int ROW_LIMIT_DEF    = 65535;

    // Special byte values.
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] SEP_RESET_VAL = 8'd44;

    // Largest values the result fields can show.
    localparam int COL_OUT_MAX = 255;
    localparam int ROW_OUT_MAX = 65535;

    // Position within the current field.
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_QSEEN  = 2'd3
    } mode_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } item_t;

    // Input register contents handed to the parser.
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    // One result beat.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        field_end;
        logic        line_end;
        logic [7:0]  column_index;
        logic [15:0] row_index;
        logic [7:0]  widest_row;
    } res_t;

endpackage

// File: src/csv_field_tokenizer_core.sv
// A byte is held in the input register, then its result in the result register with out_valid high.
// Throughput: one byte per cycle; the field state update between the input and
// result registers is the per-byte path, and a stalled output holds the input side.
// Bytes that make no result (opening quote, empty newline) still occupy the input register until taken.
// Reset clears both stage valid flags, field state and counters; separator resets to ','.
`timescale 1ns / 1ps

module csv_field_tokenizer_core #(
    parameter int COLUMN_LIMIT = cft_pkg::COLUMN_LIMIT_DEF,
    parameter int ROW_LIMIT    = cft_pkg::ROW_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        flush,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        field_end,
    output logic        line_end,
    output logic [7:0]  column_index,
    output logic [15:0] row_index,
    output logic [7:0]  widest_row
);
    import cft_pkg::*;

    stage_t stage;
    res_t   res;
    logic   take;
    logic   res_fire;
    logic   out_free;

    // Input register.
    cft_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .data_byte(data_byte),
        .flush    (flush),
        .take     (take),
        .stage    (stage)
    );

    // Field state and result logic.
    cft_parse #(
        .COLUMN_LIMIT(COLUMN_LIMIT),
        .ROW_LIMIT   (ROW_LIMIT)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .stage    (stage),
        .out_free (out_free),
        .take     (take),
        .res_fire (res_fire),
        .res      (res)
    );

    // Result register.
    cft_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_fire),
        .res         (res),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .field_end   (field_end),
        .line_end    (line_end),
        .column_index(column_index),
        .row_index   (row_index),
        .widest_row  (widest_row)
    );

endmodule

// File: src/cft_in_stage.sv
// Input register stage of the CSV field tokenizer.
`timescale 1ns / 1ps

module cft_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           flush,
    input  logic           take,
    output cft_pkg::stage_t stage
);
    import cft_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The register frees up when empty or when the parser takes its beat.
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.flush     <= flush;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: src/cft_parse.sv
// Field parser: separator register, field state, counters and result build.
`timescale 1ns / 1ps
`include "csv_field_tokenizer_core_defines.svh"

module cft_parse #(
    parameter int COLUMN_LIMIT = cft_pkg::COLUMN_LIMIT_DEF,
    parameter int ROW_LIMIT    = cft_pkg::ROW_LIMIT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    input  cft_pkg::stage_t stage,
    input  logic            out_free,
    output logic            take,
    output logic            res_fire,
    output cft_pkg::res_t   res
);
    import cft_pkg::*;

    localparam int CW  = $clog2(COLUMN_LIMIT + 1);
    localparam int RW  = $clog2(ROW_LIMIT + 1);
    localparam int CXW = (CW > 8) ? CW : 8;
    localparam int RXW = (RW > 16) ? RW : 16;

    logic [7:0]    sep_reg;
    mode_t         mode_reg, mode_next;
    logic          line_open_reg, line_open_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] widest_reg, widest_next;

    logic [CW-1:0]  col_inc;
    logic [RW-1:0]  row_inc;
    logic           do_emit, do_endf, do_endl;
    logic [7:0]     ebyte;
    logic [7:0]     b;
    logic [CXW-1:0] col_ext, widest_ext;
    logic [RXW-1:0] row_ext;

    // A beat moves on only when the result register can take a result.
    assign take      = stage.valid && out_free;
    assign cfg_ready = 1'b1;
    assign b         = stage.item.data_byte;

    // Saturating increments.
    assign col_inc = (col_reg >= CW'(COLUMN_LIMIT)) ? col_reg : col_reg + 1'b1;
    assign row_inc = (row_reg >= RW'(ROW_LIMIT)) ? row_reg : row_reg + 1'b1;

    // Decide the action for this byte.
    always_comb
    begin
        do_emit        = 1'b0;
        do_endf        = 1'b0;
        do_endl        = 1'b0;
        ebyte          = b;
        mode_next      = mode_reg;
        line_open_next = line_open_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        widest_next    = widest_reg;

        if (stage.item.flush || b == CH_NEWLINE)
        begin
            do_endl = line_open_reg;
        end
        else
        begin
            line_open_next = 1'b1;
            unique case (mode_reg)
                MODE_START:
                begin
                    priority if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTED;
                    end
                    else if (b == sep_reg)
                    begin
                        do_endf = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        do_emit   = 1'b1;
                    end
                end
                MODE_PLAIN:
                begin
                    if (b == sep_reg)
                    begin
                        do_endf = 1'b1;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                MODE_QUOTED:
                begin
                    if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                MODE_QSEEN:
                begin
                    priority if (b == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTED;
                        do_emit   = 1'b1;
                    end
                    else if (b == sep_reg)
                    begin
                        do_endf = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        do_emit   = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_START;
                end
            endcase
        end

        // Field and line closing update the counters.
        if (do_endf)
        begin
            col_next  = col_inc;
            mode_next = MODE_START;
        end
        if (do_endl)
        begin
            if (col_inc > widest_reg)
            begin
                widest_next = col_inc;
            end
            row_next       = row_inc;
            col_next       = '0;
            mode_next      = MODE_START;
            line_open_next = 1'b0;
        end
    end

    // Result fields, clamped to the output widths.
    assign col_ext    = CXW'(col_reg);
    assign row_ext    = RXW'(row_reg);
    assign widest_ext = CXW'(widest_next);

    always_comb
    begin
        res.out_byte     = do_emit ? ebyte : 8'd0;
        res.byte_valid   = do_emit;
        res.field_end    = do_endf || do_endl;
        res.line_end     = do_endl;
        res.column_index = (col_ext > CXW'(COL_OUT_MAX)) ? 8'hFF : col_ext[7:0];
        res.row_index    = (row_ext > RXW'(ROW_OUT_MAX)) ? 16'hFFFF : row_ext[15:0];
        res.widest_row   = (widest_ext > CXW'(COL_OUT_MAX)) ? 8'hFF : widest_ext[7:0];
    end

    assign res_fire = take && (do_emit || do_endf || do_endl);

    // Separator register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET_VAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sep_reg <= cfg_data;
        end
    end

    // Parser state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            line_open_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            widest_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            line_open_reg <= line_open_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            widest_reg    <= widest_next;
        end
    end

    // A field or line mark never carries a content byte.
    `CFT_ASSERT_IMP(a_mark_no_byte, clk, rst_n, res_fire && res.field_end, !res.byte_valid,
        "field mark carries a content byte")
    // A line end always closes the field too.
    `CFT_ASSERT_IMP(a_line_has_field, clk, rst_n, res_fire && res.line_end, res.field_end,
        "line end without field end")
    // After a line closes the column restarts and no line is open.
    `CFT_ASSERT_NXT(a_line_resets, clk, rst_n, res_fire && res.line_end,
        col_reg == '0 && !line_open_reg && mode_reg == MODE_START,
        "line end did not reset column state")
    // The widest count never falls below the line just closed.
    `CFT_ASSERT_NXT(a_widest_grows, clk, rst_n, take && do_endl,
        widest_reg >= $past(col_inc), "widest count below closed line")

endmodule

// File: src/cft_out_stage.sv
// Result register stage of the CSV field tokenizer.
`timescale 1ns / 1ps

module cft_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  cft_pkg::res_t res,
    output logic          out_free,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          field_end,
    output logic          line_end,
    output logic [7:0]    column_index,
    output logic [15:0]   row_index,
    output logic [7:0]    widest_row
);
    import cft_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Space is there when empty or when the waiting beat leaves this cycle.
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = res_reg.out_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign field_end    = res_reg.field_end;
    assign line_end     = res_reg.line_end;
    assign column_index = res_reg.column_index;
    assign row_index    = res_reg.row_index;
    assign widest_row   = res_reg.widest_row;

endmodule

// File: dv/csv_field_tokenizer_checker.sv
// Scoreboard that predicts every result beat of the CSV field tokenizer and compares it.
`timescale 1ns / 1ps

module csv_field_tokenizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        flush,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        field_end,
    input  logic        line_end,
    input  logic [7:0]  column_index,
    input  logic [15:0] row_index,
    input  logic [7:0]  widest_row,
    output int          mismatch_count,
    output int          pending_count,
    output int          beats_checked,
    output int          lines_closed
);
    import cft_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the tokenizer state and its separator register.
    logic [7:0] sep_byte;
    mode_t      field_state;
    logic       in_line;
    int         col_count;
    int         row_count;
    int         widest_count;
    res_t       expected_q[$];

    function automatic int bump(input int v, input int lim);
        return (v >= lim) ? lim : v + 1;
    endfunction

    function automatic logic [7:0] clamp_col(input int v);
        return (v > COL_OUT_MAX) ? 8'(COL_OUT_MAX) : 8'(v);
    endfunction

    function automatic logic [15:0] clamp_row(input int v);
        return (v > ROW_OUT_MAX) ? 16'(ROW_OUT_MAX) : 16'(v);
    endfunction

    // Advances the shadow state by one input beat; returns 1 when the beat yields a result.
    function automatic bit tokenize_byte(input logic [7:0] b, input logic last,
                                         output res_t r);
        int fields;
        bit gives_byte;
        bit ends_field;
        r = '0;
        r.column_index = clamp_col(col_count);
        r.row_index    = clamp_row(row_count);
        gives_byte     = 1'b0;
        ends_field     = 1'b0;

        // A newline or a flush closes an open line; with no open line it is dropped.
        if (last || b == CH_NEWLINE) begin
            if (!in_line)
                return 1'b0;
            fields = bump(col_count, COLUMN_LIMIT_DEF);
            if (fields > widest_count)
                widest_count = fields;
            r.field_end  = 1'b1;
            r.line_end   = 1'b1;
            r.widest_row = clamp_col(widest_count);
            row_count    = bump(row_count, ROW_LIMIT_DEF);
            col_count    = 0;
            field_state  = MODE_START;
            in_line      = 1'b0;
            return 1'b1;
        end

        in_line      = 1'b1;
        r.widest_row = clamp_col(widest_count);
        case (field_state)
            MODE_START: begin
                if (b == CH_QUOTE)
                    field_state = MODE_QUOTED;
                else if (b == sep_byte)
                    ends_field = 1'b1;
                else begin
                    field_state = MODE_PLAIN;
                    gives_byte  = 1'b1;
                end
            end
            MODE_PLAIN: begin
                if (b == sep_byte)
                    ends_field = 1'b1;
                else
                    gives_byte = 1'b1;
            end
            MODE_QUOTED: begin
                if (b == CH_QUOTE)
                    field_state = MODE_QSEEN;
                else
                    gives_byte = 1'b1;
            end
            default: begin
                // After a quote inside quotes: a second quote is a literal one,
                // anything else closes the quoting.
                if (b == CH_QUOTE) begin
                    field_state = MODE_QUOTED;
                    gives_byte  = 1'b1;
                end else if (b == sep_byte)
                    ends_field = 1'b1;
                else begin
                    field_state = MODE_PLAIN;
                    gives_byte  = 1'b1;
                end
            end
        endcase

        if (gives_byte) begin
            r.out_byte   = b;
            r.byte_valid = 1'b1;
        end
        if (ends_field) begin
            r.field_end = 1'b1;
            col_count   = bump(col_count, COLUMN_LIMIT_DEF);
            field_state = MODE_START;
        end
        return gives_byte || ends_field;
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf("byte=%02h bv=%0b fe=%0b le=%0b col=%0d row=%0d widest=%0d",
                         r.out_byte, r.byte_valid, r.field_end, r.line_end,
                         r.column_index, r.row_index, r.widest_row);
    endfunction

    // Compare result beats first, then predict from the input beat, then track the register.
    always @(posedge clk or negedge rst_n) begin
        res_t got;
        res_t want;
        if (!rst_n) begin
            sep_byte       = SEP_RESET_VAL;
            field_state    = MODE_START;
            in_line        = 1'b0;
            col_count      = 0;
            row_count      = 0;
            widest_count   = 0;
            expected_q.delete();
            mismatch_count = 0;
            beats_checked  = 0;
            lines_closed   = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{out_byte, byte_valid, field_end, line_end,
                        column_index, row_index, widest_row};
                beats_checked++;
                if (expected_q.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result beat with nothing expected: %s",
                                 $realtime, describe(got));
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.line_end)
                        lines_closed++;
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.field_end !== want.field_end || got.line_end !== want.line_end ||
                        got.column_index !== want.column_index ||
                        got.row_index !== want.row_index || got.widest_row !== want.widest_row)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: wrong result beat\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(got));
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (tokenize_byte(data_byte, flush, want))
                    expected_q = {expected_q, want};
            end
            if (cfg_valid && cfg_ready)
                sep_byte = cfg_data;
        end
        pending_count = expected_q.size();
    end

endmodule

// File: dv/csv_field_tokenizer_core_tb.sv
// Testbench top for the CSV field tokenizer: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module csv_field_tokenizer_core_tb;
    import cft_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_BEATS = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam logic [8:0] FLUSH_BEAT = 9'h100;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        flush;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        field_end;
    logic        line_end;
    logic [7:0]  column_index;
    logic [15:0] row_index;
    logic [7:0]  widest_row;

    int          mismatch_count;
    int          pending_count;
    int          beats_checked;
    int          lines_closed;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          beats_sent;
    int          cycle_count;
    logic [7:0]  sep_now;
    logic [8:0]  opening [27];

    csv_field_tokenizer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .flush        (flush),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .field_end    (field_end),
        .line_end     (line_end),
        .column_index (column_index),
        .row_index    (row_index),
        .widest_row   (widest_row)
    );

    csv_field_tokenizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .flush          (flush),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_end      (field_end),
        .line_end       (line_end),
        .column_index   (column_index),
        .row_index      (row_index),
        .widest_row     (widest_row),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .beats_checked  (beats_checked),
        .lines_closed   (lines_closed)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without finishing.", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one input beat, with random idle cycles ahead of it, and waits until it is taken.
    task automatic push_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        flush     <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    // Stops offering until every expected result has come, then lets the pipeline settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_BEATS) @(negedge clk);
    endtask

    task automatic write_separator(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random field byte that is neither a newline nor the separator, nor a quote unless allowed.
    function automatic logic [7:0] content_byte(input bit allow_quote);
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == CH_NEWLINE || v == sep_now || (!allow_quote && v == CH_QUOTE));
        return v;
    endfunction

    // One field: plain, or quoted with doubled quotes, separators inside and sometimes a byte after the closing quote.
    task automatic send_field();
        int len;
        len = $urandom_range(6);
        if ($urandom_range(3) == 0) begin
            push_beat(CH_QUOTE, 1'b0);
            repeat (len) begin
                if ($urandom_range(4) == 0) begin
                    push_beat(CH_QUOTE, 1'b0);
                    push_beat(CH_QUOTE, 1'b0);
                end else if ($urandom_range(5) == 0)
                    push_beat(sep_now, 1'b0);
                else
                    push_beat(content_byte(1'b0), 1'b0);
            end
            push_beat(CH_QUOTE, 1'b0);
            if ($urandom_range(3) == 0)
                push_beat(content_byte(1'b0), 1'b0);
        end else begin
            for (int i = 0; i < len; i++)
                push_beat(content_byte(i != 0), 1'b0);
        end
    endtask

    // One line of fields; a broken line may leave a quote open and may end on a flush instead of a newline.
    task automatic send_line(input bit broken);
        int nfields;
        nfields = 1 + $urandom_range(4);
        for (int i = 0; i < nfields; i++) begin
            if (i != 0)
                push_beat(sep_now, 1'b0);
            send_field();
        end
        if ($urandom_range(5) == 0)
            push_beat(sep_now, 1'b0);
        if ($urandom_range(7) == 0)
            push_beat(8'h0D, 1'b0);
        if (broken) begin
            if ($urandom_range(1) == 0) begin
                push_beat(sep_now, 1'b0);
                push_beat(CH_QUOTE, 1'b0);
                push_beat(content_byte(1'b1), 1'b0);
            end
            if ($urandom_range(1) == 0)
                push_beat(8'($urandom_range(255)), 1'b1);
            else
                push_beat(CH_NEWLINE, 1'b0);
        end else begin
            push_beat(CH_NEWLINE, 1'b0);
            if ($urandom_range(6) == 0)
                push_beat(CH_NEWLINE, 1'b0);
        end
    endtask

    // Short burst of arbitrary beats, weighted toward the special bytes.
    task automatic send_noise();
        int len;
        len = 1 + $urandom_range(11);
        repeat (len) begin
            case ($urandom_range(7))
                0:       push_beat(CH_QUOTE, 1'b0);
                1:       push_beat(sep_now, 1'b0);
                2:       push_beat(CH_NEWLINE, 1'b0);
                3:       push_beat(8'($urandom_range(255)), 1'b1);
                default: push_beat(8'($urandom_range(255)), 1'b0);
            endcase
        end
    endtask

    // One phase: drain, set the separator, then random lines and noise under the given idling and stalls.
    task automatic run_phase(input logic [7:0] sep, input int idle_pct, input int stall_pct,
                             input int beats, input int hold);
        int stop_at;
        wait_drained();
        write_separator(sep);
        sep_now        = sep;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_request   = hold;
        stop_at        = beats_sent + beats;
        while (beats_sent < stop_at) begin
            case ($urandom_range(9))
                0:       send_noise();
                1:       send_line(1'b1);
                default: send_line(1'b0);
            endcase
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 8'h00;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        flush          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        beats_sent     = 0;
        sep_now        = SEP_RESET_VAL;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening with the reset separator: dropped newline and flush, a field
        // of one escaped quote, a quote inside a plain field, text after a closing quote,
        // a trailing separator, byte extremes with CR, an unterminated quote holding a
        // separator, and a flush that closes the last line.
        opening = '{
            {1'b0, CH_NEWLINE}, FLUSH_BEAT,
            {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
            {1'b0, SEP_RESET_VAL},
            9'h063, {1'b0, CH_QUOTE}, 9'h064, {1'b0, SEP_RESET_VAL}, {1'b0, CH_QUOTE},
            9'h071, {1'b0, CH_QUOTE}, 9'h07A, {1'b0, SEP_RESET_VAL}, {1'b0, CH_NEWLINE},
            9'h000, 9'h0FF, 9'h00D, {1'b0, CH_NEWLINE},
            {1'b0, CH_QUOTE}, {1'b0, SEP_RESET_VAL}, {1'b0, CH_NEWLINE},
            9'h078, FLUSH_BEAT, FLUSH_BEAT
        };
        foreach (opening[i])
            push_beat(opening[i][7:0], opening[i][8]);

        // Random phases; the first holds off the result side so the input stalls.
        run_phase(SEP_RESET_VAL, 0, 0, 40, HOLD_CYCLES);
        run_phase(8'hFF, 63, 0, 40, 0);
        run_phase(8'h00, 0, 63, 40, 0);
        run_phase(8'h09, 24, 24, 40, 0);
        run_phase(CH_NEWLINE, 0, 0, 30, 0);
        run_phase(CH_QUOTE, 63, 0, 30, 0);
        run_phase(8'h3B, 0, 63, 30, 0);
        run_phase(SEP_RESET_VAL, 24, 24, 30, 0);

        // Close whatever the last phase left open, then a line of empty fields long
        // enough to saturate the column and widest counts.
        push_beat(CH_NEWLINE, 1'b0);
        repeat (COLUMN_LIMIT_DEF + 8) push_beat(sep_now, 1'b0);
        push_beat(CH_NEWLINE, 1'b0);

        wait_drained();
        $display("Sent %0d input beats over eight phases with seven separators and four idling patterns;",
                 beats_sent);
        $display("checked %0d result beats across %0d closed lines.", beats_checked,
                 lines_closed);
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: csv_field_tokenizer_core.f
+incdir+src
src/cft_pkg.sv
src/cft_in_stage.sv
src/cft_parse.sv
src/cft_out_stage.sv
src/csv_field_tokenizer_core.sv
dv/csv_field_tokenizer_checker.sv
dv/csv_field_tokenizer_core_tb.sv
